// ===== sv/ritp_pkg.sv =====
// Package for the radix integer text parser: word types, character
// constants and the digit decode function. No dependencies.
package ritp_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] parsed_value;
    logic               parse_ok;
  } out_word_t;

  localparam int unsigned RadixW   = 6;
  localparam int unsigned DigitW   = 7;
  localparam int unsigned AccW     = 64;

  localparam logic [RadixW-1:0] RADIX_RESET = 6'd10;
  localparam logic [RadixW-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RadixW-1:0] RADIX_MAX   = 6'd36;

  localparam logic [DigitW-1:0] NOT_A_DIGIT = 7'd99;

  localparam logic [7:0] WS_MAX     = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_APOS  = 8'h27;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;

  // register word index (paddr[2])
  localparam logic REG_RADIX = 1'b0;

  function automatic logic [DigitW-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = c - CHAR_0;
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      d = c - CHAR_LA + 8'd10;
    end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
      d = c - CHAR_UA + 8'd10;
    end else begin
      d = {1'b0, NOT_A_DIGIT};
    end
    return d[DigitW-1:0];
  endfunction

endpackage

// ===== sv/ritp_parse_core.sv =====
// Parse state and per-byte next-state logic: phase, sign, accumulator.
// Depends on ritp_pkg.
module ritp_parse_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  ritp_pkg::in_word_t      word_i,
  input  logic [5:0]              radix_i,
  output ritp_pkg::out_word_t     result_o
);
  import ritp_pkg::*;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_TRAIL  = 2'd2,
    PH_FAIL   = 2'd3
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic              seen_q, seen_d;
  logic [AccW-1:0]   acc_q, acc_d;

  logic [7:0]        c;
  logic [DigitW-1:0] dig;
  logic              radix_ok, is_ws, is_skip, dig_ok, run;
  logic [AccW-1:0]   addend, mac;
  logic              ok;

  assign c        = word_i.text_byte;
  assign dig      = digit_of(c);
  assign radix_ok = (radix_i >= RADIX_MIN) && (radix_i <= RADIX_MAX);
  assign is_ws    = (c <= WS_MAX);
  assign is_skip  = (c == CHAR_APOS) || (c == CHAR_QUOTE) || (c == CHAR_UNDER);
  assign dig_ok   = (dig < {1'b0, radix_i});

  // accumulate in signed form: -(a*r+d) == (-a)*r - d mod 2^64
  assign addend = neg_q ? (AccW'(0) - AccW'(dig)) : AccW'(dig);
  assign mac    = (acc_q * AccW'(radix_i)) + addend;

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    seen_d  = seen_q;
    acc_d   = acc_q;
    run     = 1'b0;
    if (!radix_ok) begin
      phase_d = PH_FAIL;
    end else begin
      unique case (phase_q)
        PH_LEAD: begin
          priority if (is_ws) begin
            phase_d = PH_LEAD;
          end else if (c == CHAR_PLUS) begin
            phase_d = PH_DIGITS;
          end else if (c == CHAR_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_DIGITS;
          end else begin
            run = 1'b1;
          end
        end
        PH_DIGITS: run = 1'b1;
        PH_TRAIL: begin
          if (!is_ws) phase_d = PH_FAIL;
        end
        PH_FAIL: phase_d = PH_FAIL;
        default: phase_d = PH_FAIL;
      endcase
    end
    if (run) begin
      priority if (is_skip) begin
        phase_d = PH_DIGITS;
      end else if (dig_ok) begin
        acc_d   = mac;
        seen_d  = 1'b1;
        phase_d = PH_DIGITS;
      end else begin
        phase_d = is_ws ? PH_TRAIL : PH_FAIL;
      end
    end
  end

  assign ok = seen_d && (phase_d != PH_FAIL);
  assign result_o.parse_ok     = ok;
  assign result_o.parsed_value = ok ? acc_d : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      acc_q   <= '0;
    end else if (step_i) begin
      if (word_i.is_last) begin
        phase_q <= PH_LEAD;
        neg_q   <= 1'b0;
        seen_q  <= 1'b0;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        seen_q  <= seen_d;
        acc_q   <= acc_d;
      end
    end
  end

endmodule

// ===== sv/radix_integer_text_parser_unit.sv =====
// Top level of the radix integer text parser: input and result registers,
// radix configuration register, parse core. Depends on ritp_pkg, ritp_parse_core.
//
// Takes one text byte per word and returns one result word (value, ok) for
// each word marked last. A new byte is accepted every cycle unless the input
// stalls; a result passes through the input register, then the per-byte
// multiply-accumulate in the parse core and the result register.
// Input stall rises only while a held result is stalled and the waiting byte
// is a last byte. Radix sits at byte address 0; change it only while idle.
module radix_integer_text_parser_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ritp_pkg::in_word_t    in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ritp_pkg::out_word_t   out_word_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ritp_pkg::*;

  logic              in_valid_q;
  in_word_t          in_word_q;
  logic              out_valid_q;
  out_word_t         out_word_q;
  logic [RadixW-1:0] radix_q;
  logic              advance, load_in;
  out_word_t         result;

  assign advance    = in_valid_q && (!in_word_q.is_last || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load_in    = !in_stall_o;

  ritp_parse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (in_word_q),
    .radix_i  (radix_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in && in_valid_i) in_word_q <= in_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_word_q.is_last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_word_q.is_last) out_word_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIX)) begin
      radix_q <= pwdata[RadixW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIX) ? {{(32-RadixW){1'b0}}, radix_q} : 32'd0;

endmodule

// ===== sv/ritp_checker.sv =====
// Port-level checks for the radix integer text parser, bound to the top.
// Depends on ritp_pkg and radix_integer_text_parser_unit.
module ritp_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input ritp_pkg::in_word_t   in_word_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input ritp_pkg::out_word_t  out_word_o,
  input logic                 pready
);
  import ritp_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // failed parse reports zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.parse_ok |-> out_word_o.parsed_value == 64'sd0)
    else $error("failed parse with nonzero value");

  // a new result follows an accepted last byte
  a_rise_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && in_word_i.is_last, 2))
    else $error("result without last byte");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind radix_integer_text_parser_unit ritp_checker u_ritp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o),
  .pready      (pready)
);
